### rtl/lmcd_pkg.sv
// Shared constants and types of the local maximum centroid detector.
package lmcd_pkg;

  localparam int MAX_RADIUS_DEF = 3;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int PIXEL_BITS_DEF = 16;

  localparam int RAD_CFG_W = 2;
  localparam int HGT_CFG_W = 10;
  localparam int WID_W = 13;
  localparam int COL_W = 12;
  localparam int WIDTH_LIMIT = 4096;

  localparam int ROW_OUT_W = 18;
  localparam int COL_OUT_W = 21;
  localparam int FRAC_BITS = 8;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WIDTH = 2'd2;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [RAD_CFG_W-1:0] radius;
    logic [HGT_CFG_W-1:0] height;
    logic [WID_W-1:0]     width;
  } cfg_t;

endpackage

### rtl/lmcd_fifo.sv
// Small queue of particle candidates between the window scan and the divider.
module lmcd_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);
  localparam int D = lmcd_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(D);
  localparam int CW = $clog2(D + 1);

  logic [W-1:0]  slots [D];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full = (count == CW'(D));
  assign empty = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(D - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(D - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(D))
    else $error("queue count out of range");

endmodule

### rtl/lmcd_front.sv
// Column store, position counters and window scan that finds local maxima.
module lmcd_front #(
  parameter int MAX_RADIUS = lmcd_pkg::MAX_RADIUS_DEF,
  parameter int MAX_HEIGHT = lmcd_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = lmcd_pkg::PIXEL_BITS_DEF,
  parameter int SUM_W = 22,
  parameter int OFF_W = 25,
  parameter int ENT_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lmcd_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIXEL_BITS-1:0] pixel,
  input  logic                  frame_start,
  output logic                  push,
  output logic [ENT_W-1:0]      push_data,
  input  logic                  full
);
  localparam int WIN = 2 * MAX_RADIUS + 1;
  localparam int WB = $clog2(WIN);
  localparam int RAD_W = $clog2(MAX_RADIUS + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int MEM_D = WIN * MAX_HEIGHT;
  localparam int AW = $clog2(MEM_D);
  localparam int WID_W = lmcd_pkg::WID_W;
  localparam int COL_W = lmcd_pkg::COL_W;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_GATH = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0] state;

  logic [PIXEL_BITS-1:0] mem [MEM_D];
  logic [PIXEL_BITS-1:0] mem_q;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;

  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;
  logic [WB-1:0]    slot_count;

  logic [RAD_W-1:0] r_eff;
  logic [HGT_W-1:0] h_eff;
  logic [WID_W-1:0] w_eff;
  logic [WB-1:0]    span;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [WB-1:0]    slot;
  logic             accept;
  logic             hit;

  logic [RAD_W-1:0] r_l;
  logic [WB-1:0]    span_l;
  logic [ROW_W-1:0] wrow;
  logic [COL_W-1:0] wcol;
  logic [ROW_W-1:0] wrow0;
  logic [WB-1:0]    rslot;
  logic [WB-1:0]    dc;
  logic [WB-1:0]    dr;
  logic             iss;

  logic             rv;
  logic [WB-1:0]    rdc;
  logic [WB-1:0]    rdr;
  logic             rlast;

  logic [SUM_W-1:0]      sum;
  logic signed [OFF_W-1:0] sdx;
  logic signed [OFF_W-1:0] sdy;
  logic [PIXEL_BITS-1:0] centre;
  logic [PIXEL_BITS-1:0] max_other;

  logic signed [WB:0]              dxs;
  logic signed [WB:0]              dys;
  logic signed [PIXEL_BITS+WB+1:0] px;
  logic signed [PIXEL_BITS+WB+1:0] py;
  logic                            is_c;
  logic                            is_peak;
  logic [WID_W-1:0]                ch1;
  logic [WID_W-1:0]                cw1;

  always_comb begin
    if (cfg.radius == '0) begin
      r_eff = RAD_W'(1);
    end else if (32'(cfg.radius) > 32'(MAX_RADIUS)) begin
      r_eff = RAD_W'(MAX_RADIUS);
    end else begin
      r_eff = RAD_W'(cfg.radius);
    end
    if (cfg.height == '0) begin
      h_eff = HGT_W'(1);
    end else if (32'(cfg.height) > 32'(MAX_HEIGHT)) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = HGT_W'(cfg.height);
    end
    if (cfg.width == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(cfg.width) > 32'(lmcd_pkg::WIDTH_LIMIT)) begin
      w_eff = WID_W'(lmcd_pkg::WIDTH_LIMIT);
    end else begin
      w_eff = cfg.width;
    end
  end

  assign span = WB'(2 * 32'(r_eff));
  assign row = frame_start ? '0 : row_count;
  assign col = frame_start ? '0 : col_count;
  assign slot = frame_start ? '0 : slot_count;
  assign in_stall = (state != F_IDLE);
  assign accept = in_valid && (state == F_IDLE);
  assign hit = (32'(col) >= 32'(span)) && (32'(row) >= 32'(span)) &&
               (32'(row) < 32'(h_eff)) && (32'(col) < 32'(w_eff));

  assign waddr = AW'(32'(slot) * MAX_HEIGHT + 32'(row));
  assign raddr = AW'(32'(rslot) * MAX_HEIGHT + 32'(wrow0) + 32'(dr));

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[waddr] <= pixel;
    end
    mem_q <= mem[raddr];
  end

  // Offsets of the returning beat from the centre.
  assign dxs = $signed({1'b0, rdc}) - $signed({1'b0, WB'(r_l)});
  assign dys = $signed({1'b0, rdr}) - $signed({1'b0, WB'(r_l)});
  assign px = $signed({1'b0, mem_q}) * dxs;
  assign py = $signed({1'b0, mem_q}) * dys;
  assign is_c = (rdc == WB'(r_l)) && (rdr == WB'(r_l));
  assign is_peak = centre > max_other;
  assign ch1 = WID_W'(32'(wrow) - 32'(r_l) + 1);
  assign cw1 = WID_W'(32'(wcol) - 32'(r_l) + 1);
  assign push = (state == F_PUSH) && is_peak && !full;
  assign push_data = {sum, sdx, sdy, ch1, cw1, centre};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      row_count <= '0;
      col_count <= '0;
      slot_count <= '0;
      iss <= 1'b0;
      rv <= 1'b0;
    end else begin
      rv <= 1'b0;
      case (state)
        F_IDLE: begin
          if (accept) begin
            if (32'(row) + 1 >= 32'(h_eff)) begin
              row_count <= '0;
              if (32'(col) + 1 >= 32'(w_eff)) begin
                col_count <= '0;
                slot_count <= '0;
              end else begin
                col_count <= col + 1'b1;
                slot_count <= (slot == WB'(WIN - 1)) ? '0 : slot + 1'b1;
              end
            end else begin
              row_count <= row + 1'b1;
              col_count <= col;
              slot_count <= slot;
            end
            if (hit) begin
              state <= F_GATH;
              iss <= 1'b1;
            end
          end
        end
        F_GATH: begin
          if (iss) begin
            rv <= 1'b1;
            if (dr == span_l && dc == span_l) begin
              iss <= 1'b0;
            end
          end
          if (rv && rlast) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!is_peak || !full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_l <= r_eff;
      span_l <= span;
      wrow <= row;
      wcol <= col;
      wrow0 <= ROW_W'(32'(row) - 32'(span));
      rslot <= (slot >= span) ? slot - span : WB'(32'(slot) + WIN - 32'(span));
      dc <= '0;
      dr <= '0;
      sum <= '0;
      sdx <= '0;
      sdy <= '0;
      centre <= '0;
      max_other <= '0;
    end else begin
      if (state == F_GATH && iss) begin
        rdc <= dc;
        rdr <= dr;
        rlast <= (dr == span_l) && (dc == span_l);
        // advance down the column, then to the next slot
        if (dr == span_l) begin
          dr <= '0;
          dc <= dc + 1'b1;
          rslot <= (rslot == WB'(WIN - 1)) ? '0 : rslot + 1'b1;
        end else begin
          dr <= dr + 1'b1;
        end
      end
      if (rv) begin
        sum <= sum + SUM_W'(mem_q);
        sdx <= sdx + OFF_W'(px);
        sdy <= sdy + OFF_W'(py);
        if (is_c) begin
          centre <= mem_q;
        end else if (mem_q > max_other) begin
          max_other <= mem_q;
        end
      end
    end
  end

endmodule

### rtl/lmcd_back.sv
// Centroid arithmetic: weighted totals and a shared bit-serial divider.
module lmcd_back #(
  parameter int PIXEL_BITS = lmcd_pkg::PIXEL_BITS_DEF,
  parameter int SUM_W = 22,
  parameter int OFF_W = 25,
  parameter int ENT_W = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           empty,
  input  logic [ENT_W-1:0]               pop_data,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lmcd_pkg::ROW_OUT_W-1:0] row_center,
  output logic [lmcd_pkg::COL_OUT_W-1:0] col_center,
  output logic [PIXEL_BITS-1:0]          peak_value
);
  localparam int WID_W = lmcd_pkg::WID_W;
  localparam int PRD_W = SUM_W + WID_W;
  localparam int TOT_W = PRD_W + 1;
  localparam int NUM_W = TOT_W + lmcd_pkg::FRAC_BITS + 1;
  localparam int DEN_W = SUM_W + 1;
  localparam int Q_W = lmcd_pkg::COL_OUT_W;
  localparam int CNT_W = $clog2(Q_W);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL = 3'd1;
  localparam logic [2:0] B_ADD = 3'd2;
  localparam logic [2:0] B_LDR = 3'd3;
  localparam logic [2:0] B_DIVR = 3'd4;
  localparam logic [2:0] B_LDC = 3'd5;
  localparam logic [2:0] B_DIVC = 3'd6;
  localparam logic [2:0] B_OUT = 3'd7;

  logic [2:0] state;

  logic [SUM_W-1:0]        sum;
  logic signed [OFF_W-1:0] sdx;
  logic signed [OFF_W-1:0] sdy;
  logic [WID_W-1:0]        ch1;
  logic [WID_W-1:0]        cw1;
  logic [PIXEL_BITS-1:0]   peak;

  logic [PRD_W-1:0]        prod_row;
  logic [PRD_W-1:0]        prod_col;
  logic signed [TOT_W-1:0] tot_row;
  logic signed [TOT_W-1:0] tot_col;
  logic [TOT_W-1:0]        tot_sel;
  logic [NUM_W-1:0]        num;

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [Q_W-1:0]   nsh;
  logic [Q_W-1:0]   quo;
  logic [Q_W-1:0]   q_row;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign pop = (state == B_IDLE) && !empty;

  // Numerator of round(256 * total / sum), ties upward: (512 * total + sum) / (2 * sum).
  assign tot_sel = (state == B_LDR) ? unsigned'(tot_row) : unsigned'(tot_col);
  assign num = (NUM_W'(tot_sel) << (lmcd_pkg::FRAC_BITS + 1)) + NUM_W'(sum);
  assign trial = {rem, nsh[Q_W-1]};
  assign ge = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == B_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!empty) begin
            state <= B_MUL;
          end
        end
        B_MUL: state <= B_ADD;
        B_ADD: state <= B_LDR;
        B_LDR: state <= B_DIVR;
        B_DIVR: begin
          if (cnt == CNT_W'(Q_W - 1)) begin
            state <= B_LDC;
          end
        end
        B_LDC: state <= B_DIVC;
        B_DIVC: begin
          if (cnt == CNT_W'(Q_W - 1)) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      {sum, sdx, sdy, ch1, cw1, peak} <= pop_data;
    end
    if (state == B_MUL) begin
      prod_row <= PRD_W'(sum) * PRD_W'(ch1);
      prod_col <= PRD_W'(sum) * PRD_W'(cw1);
    end
    if (state == B_ADD) begin
      tot_row <= $signed({1'b0, prod_row}) + TOT_W'(sdy);
      tot_col <= $signed({1'b0, prod_col}) + TOT_W'(sdx);
    end
    if (state == B_LDR || state == B_LDC) begin
      rem <= DEN_W'(num >> Q_W);
      nsh <= num[Q_W-1:0];
      den <= {sum, 1'b0};
      cnt <= '0;
      quo <= '0;
    end
    if (state == B_DIVR || state == B_DIVC) begin
      rem <= ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      nsh <= {nsh[Q_W-2:0], 1'b0};
      quo <= {quo[Q_W-2:0], ge};
      cnt <= cnt + 1'b1;
      if (state == B_DIVR && cnt == CNT_W'(Q_W - 1)) begin
        q_row <= {quo[Q_W-2:0], ge};
      end
    end
    if (state == B_OUT && (!out_valid || !out_stall)) begin
      row_center <= q_row[lmcd_pkg::ROW_OUT_W-1:0];
      col_center <= quo;
      peak_value <= peak;
    end
  end

endmodule

### rtl/local_max_centroid_detector_unit.sv
// Local maximum detector with centroid: top level and configuration registers.
// Pixels enter one a cycle in column-major order. A pixel that completes a search window
// holds the input while the window is read back from the column store, one pixel a
// cycle, and while its result waits for queue space; all other pixels pass without a stall.
// Each particle then goes to the shared bit-serial divider, which sits behind a four-entry
// queue and takes a new particle only after the last result is out. Registers: window_radius
// at 0x0, image_height at 0x4, image_width at 0x8; write them only while the block is idle.
module local_max_centroid_detector_unit #(
  parameter int MAX_RADIUS = lmcd_pkg::MAX_RADIUS_DEF,
  parameter int MAX_HEIGHT = lmcd_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = lmcd_pkg::PIXEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lmcd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lmcd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lmcd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [PIXEL_BITS-1:0]           pixel,
  input  logic                            frame_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lmcd_pkg::ROW_OUT_W-1:0]  row_center,
  output logic [lmcd_pkg::COL_OUT_W-1:0]  col_center,
  output logic [PIXEL_BITS-1:0]           peak_value
);
  localparam int WIN = 2 * MAX_RADIUS + 1;
  localparam int SUM_W = PIXEL_BITS + $clog2(WIN * WIN);
  localparam int OFF_W = SUM_W + $clog2(MAX_RADIUS + 1) + 1;
  localparam int ENT_W = SUM_W + 2 * OFF_W + 2 * lmcd_pkg::WID_W + PIXEL_BITS;

  lmcd_pkg::cfg_t cfg;
  logic [1:0]       reg_idx;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  logic [ENT_W-1:0] push_data;
  logic [ENT_W-1:0] pop_data;

  assign pready = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius <= lmcd_pkg::RAD_CFG_W'(1);
      cfg.height <= lmcd_pkg::HGT_CFG_W'(512);
      cfg.width <= lmcd_pkg::WID_W'(512);
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        lmcd_pkg::REG_RADIUS: cfg.radius <= pwdata[lmcd_pkg::RAD_CFG_W-1:0];
        lmcd_pkg::REG_HEIGHT: cfg.height <= pwdata[lmcd_pkg::HGT_CFG_W-1:0];
        lmcd_pkg::REG_WIDTH: cfg.width <= pwdata[lmcd_pkg::WID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lmcd_pkg::REG_RADIUS: prdata = lmcd_pkg::APB_DATA_W'(cfg.radius);
      lmcd_pkg::REG_HEIGHT: prdata = lmcd_pkg::APB_DATA_W'(cfg.height);
      lmcd_pkg::REG_WIDTH: prdata = lmcd_pkg::APB_DATA_W'(cfg.width);
      default: prdata = '0;
    endcase
  end

  lmcd_front #(
    .MAX_RADIUS(MAX_RADIUS),
    .MAX_HEIGHT(MAX_HEIGHT),
    .PIXEL_BITS(PIXEL_BITS),
    .SUM_W(SUM_W),
    .OFF_W(OFF_W),
    .ENT_W(ENT_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pixel(pixel),
    .frame_start(frame_start),
    .push(push),
    .push_data(push_data),
    .full(full)
  );

  lmcd_fifo #(
    .W(ENT_W)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .full(full),
    .pop(pop),
    .pop_data(pop_data),
    .empty(empty)
  );

  lmcd_back #(
    .PIXEL_BITS(PIXEL_BITS),
    .SUM_W(SUM_W),
    .OFF_W(OFF_W),
    .ENT_W(ENT_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .empty(empty),
    .pop_data(pop_data),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .row_center(row_center),
    .col_center(col_center),
    .peak_value(peak_value)
  );

endmodule

### tb/local_max_centroid_detector_unit_tb.sv
// Testbench for the local maximum centroid detector: directed and random frames against a predictor.
`timescale 1ns / 100ps

module local_max_centroid_detector_unit_tb;

  localparam int MAXR = 3;
  localparam int MAXH = 512;
  localparam int SLOTS = 2 * MAXR + 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [lmcd_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [lmcd_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [lmcd_pkg::APB_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] pixel = '0;
  logic frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [lmcd_pkg::ROW_OUT_W-1:0] row_center;
  logic [lmcd_pkg::COL_OUT_W-1:0] col_center;
  logic [15:0] peak_value;

  typedef struct packed {
    logic [lmcd_pkg::ROW_OUT_W-1:0] row;
    logic [lmcd_pkg::COL_OUT_W-1:0] col;
    logic [15:0]                    peak;
  } particle_t;

  particle_t particles_due[$];
  int errors = 0;
  int items_sent = 0;
  int particles_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;

  // predictor state
  logic [1:0]  radius_reg = 2'd1;
  logic [9:0]  height_reg = 10'd512;
  logic [12:0] width_reg = 13'd512;
  logic [15:0] lines [SLOTS*MAXH];
  int row_pos = 0, col_pos = 0;

  local_max_centroid_detector_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("local_max_centroid_detector_unit_tb: FAIL");
    $finish;
  end

  function automatic longint unsigned round_q8(longint unsigned total, longint unsigned s);
    return (total * 512 + s) / (2 * s);
  endfunction

  task automatic predict_pixel(input logic [15:0] pix, input logic fs);
    int r, h, w, span, row, col, centre, v;
    longint unsigned s;
    longint sdx, sdy;
    bit peak;
    particle_t p;
    r = (radius_reg == 0) ? 1 : radius_reg;
    h = (height_reg == 0) ? 1 : (height_reg > MAXH ? MAXH : height_reg);
    w = (width_reg == 0) ? 1 : (width_reg > 4096 ? 4096 : width_reg);
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    row = row_pos;
    col = col_pos;
    span = 2 * r;
    if (row < MAXH) lines[(col % SLOTS) * MAXH + row] = pix;
    if (col >= span && row >= span && row < h && col < w) begin
      centre = lines[((col - r) % SLOTS) * MAXH + row - r];
      s = 0; sdx = 0; sdy = 0; peak = 1;
      for (int dc = 0; dc <= span; dc++)
        for (int dr = 0; dr <= span; dr++) begin
          v = lines[((col - span + dc) % SLOTS) * MAXH + row - span + dr];
          if ((dc != r || dr != r) && centre <= v) peak = 0;
          s += v;
          sdx += longint'(v) * (dc - r);
          sdy += longint'(v) * (dr - r);
        end
      if (peak) begin
        p.row = lmcd_pkg::ROW_OUT_W'(
                  round_q8(longint'(sdy + longint'(row - r + 1) * longint'(s)), s));
        p.col = lmcd_pkg::COL_OUT_W'(
                  round_q8(longint'(sdx + longint'(col - r + 1) * longint'(s)), s));
        p.peak = centre[15:0];
        particles_due.push_back(p);
      end
    end
    if (row + 1 >= h) begin
      row_pos = 0;
      col_pos = (col + 1 >= w) ? 0 : col + 1;
    end else row_pos = row + 1;
  endtask

  // check each result beat
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      particles_seen++;
      if (particles_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected particle row=%0h col=%0h peak=%0h",
                 $time, row_center, col_center, peak_value);
      end else begin
        particle_t e;
        e = particles_due.pop_front();
        if (e.row !== row_center || e.col !== col_center || e.peak !== peak_value) begin
          errors++;
          $display("%0t: expected row=%0h col=%0h peak=%0h, got row=%0h col=%0h peak=%0h",
                   $time, e.row, e.col, e.peak, row_center, col_center, peak_value);
        end
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_asked != hold_taken) begin
      hold_taken <= hold_asked;
      hold_left <= 600;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_pixel(input logic [15:0] pix, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= pix;
    frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pixel(pix, fs);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (particles_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      lmcd_pkg::REG_RADIUS: radius_reg = val[1:0];
      lmcd_pkg::REG_HEIGHT: height_reg = val[9:0];
      default:              width_reg = val[12:0];
    endcase
  endtask

  task automatic set_frame(input int r, input int h, input int w);
    write_reg(lmcd_pkg::REG_RADIUS, r);
    write_reg(lmcd_pkg::REG_HEIGHT, h);
    write_reg(lmcd_pkg::REG_WIDTH, w);
  endtask

  // one frame; mode 0 sparse peaks on low noise, 1 full random, 2 flat
  task automatic send_frame(input int h, input int w, input int mode);
    logic [15:0] v;
    for (int c = 0; c < w; c++)
      for (int rr = 0; rr < h; rr++) begin
        case (mode)
          0: v = ($urandom_range(9) == 0) ? 16'($urandom_range(65535, 30000))
                                          : 16'($urandom_range(200));
          1: v = 16'($urandom);
          default: v = 16'h1234;
        endcase
        send_pixel(v, (c == 0 && rr == 0));
      end
  endtask

  task automatic test_directed();
    set_frame(1, 3, 3);
    // single bright centre, then near-max surrounding values, then a tie
    for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 16'hFFFF : 16'h0000, i == 0);
    for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 16'hFFFF : 16'hFFFE, i == 0);
    for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 16'h0001 : 16'h0001, i == 0);
    // frame too small for radius 3, then radius zero
    write_reg(lmcd_pkg::REG_RADIUS, 3);
    send_frame(3, 3, 1);
    write_reg(lmcd_pkg::REG_RADIUS, 0);
    // a following frame without frame_start wraps by itself
    for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 16'h8000 : 16'h0003, 1'b0);
  endtask

  task automatic test_random(input int budget);
    int r, h, w;
    while (budget > 0) begin
      r = $urandom_range(3, 1);
      h = $urandom_range(12, 2 * r + 1);
      w = $urandom_range(10, 2 * r + 1);
      set_frame(r, h, w);
      send_frame(h, w, ($urandom_range(9) == 0) ? 2 : ($urandom_range(3) == 0) ? 1 : 0);
      budget -= h * w;
    end
  endtask

  task automatic test_extremes();
    // full-height columns: two whole columns and the top of the third
    set_frame(1, 512, 3);
    send_frame(512, 2, 0);
    for (int i = 0; i < 40; i++)
      send_pixel(($urandom_range(9) == 0) ? 16'($urandom_range(65535, 30000))
                                          : 16'($urandom_range(200)), 1'b0);
    set_frame(2, 5, 4096);
    send_frame(5, 8, 0);
    set_frame(3, 7, 7);
    send_frame(7, 7, 1);
  endtask

  task automatic test_backpressure();
    set_frame(1, 12, 12);
    hold_asked++;
    send_frame(12, 12, 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extremes();
    test_backpressure();
    test_random(120);
    send_idle_pct = 85;
    test_random(120);
    send_idle_pct = 0; recv_stall_pct = 85;
    test_random(120);
    send_idle_pct = 24; recv_stall_pct = 24;
    test_random(120);
    send_idle_pct = 0; recv_stall_pct = 0;
    drain();
    $display("Sent %0d pixels over radii 1..3, columns up to 512 high and widths up to 4096.",
             items_sent);
    $display("Checked %0d particles under idle, stall and hold-off phases.", particles_seen);
    if (errors == 0) $display("local_max_centroid_detector_unit_tb: PASS");
    else $display("local_max_centroid_detector_unit_tb: FAIL");
    $finish;
  end
endmodule

### filelist.f
rtl/lmcd_pkg.sv
rtl/lmcd_fifo.sv
rtl/lmcd_front.sv
rtl/lmcd_back.sv
rtl/local_max_centroid_detector_unit.sv
tb/local_max_centroid_detector_unit_tb.sv
